[rtl/chd_pkg.sv]
// Package for the chunked body decoder: item types, status codes and reset constants.
// No dependencies; every other file imports it.
package chd_pkg;

  localparam int LINE_MAX_DEF  = 256;
  localparam int SIZE_BITS_DEF = 31;

  localparam int LIMIT_W = 9;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;

  localparam int COUNT_W = 31;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 31'h7FFF_FFFF;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic [7:0]         out_byte;
    logic               payload_valid;
    logic [1:0]         body_status;
    logic [COUNT_W-1:0] total_bytes;
  } out_item_t;

endpackage

[rtl/http_chunked_body_decoder.sv]
// Chunked HTTP body decoder, one body byte per word.
// The result word of an accepted byte is loaded into the output register at the accepting edge.
// Throughput: one byte per cycle; input stalls only while a result is held and stalled.
// The parse state update and the result come from one pass of logic ahead of the output register.
// Reset (rst, synchronous): clears the decode state and out_valid, sets line_limit to 256.
// Depends on chd_pkg, chd_parser and chd_outreg.
module http_chunked_body_decoder import chd_pkg::*; #(
  parameter int LINE_MAX  = LINE_MAX_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_data,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data
);

  logic [LIMIT_W-1:0] line_limit;
  logic               accept;
  logic               busy;
  out_item_t          result;

  assign in_stall = busy;
  assign accept   = in_valid & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      line_limit <= cfg_wr_data;
    end
  end

  chd_parser #(
    .LINE_MAX  (LINE_MAX),
    .SIZE_BITS (SIZE_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .item       (in_data),
    .line_limit (line_limit),
    .result     (result)
  );

  chd_outreg u_outreg (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .load_data (result),
    .busy      (busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

[rtl/chd_parser.sv]
// Chunk parser: holds the decode state and works out the next state and the word's result.
// Depends on chd_pkg.
module chd_parser import chd_pkg::*; #(
  parameter int LINE_MAX  = LINE_MAX_DEF,
  parameter int SIZE_BITS = SIZE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  in_item_t           item,
  input  logic [LIMIT_W-1:0] line_limit,
  output out_item_t          result
);

  localparam int LcW  = $clog2(LINE_MAX + 1);
  localparam int LimW = (LcW > LIMIT_W) ? LcW : LIMIT_W;
  localparam logic [LimW-1:0] LineMaxV = LimW'(LINE_MAX);

  localparam logic [2:0] PH_SIZE = 3'd0;
  localparam logic [2:0] PH_DATA = 3'd1;
  localparam logic [2:0] PH_TAIL = 3'd2;
  localparam logic [2:0] PH_FOOT = 3'd3;
  localparam logic [2:0] PH_DONE = 3'd4;
  localparam logic [2:0] PH_ERR  = 3'd5;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Returns {is_hex, value}.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  logic [2:0]           phase, phase_next;
  logic [LcW-1:0]       line_count, line_count_next;
  logic [SIZE_BITS-1:0] size_accum, size_accum_next;
  logic [SIZE_BITS-1:0] bytes_left, bytes_left_next;
  logic [COUNT_W-1:0]   delivered, delivered_next;
  logic                 number_closed, number_closed_next;
  logic                 saw_digit, saw_digit_next;

  logic [LimW-1:0] lim_ext, lim_wide;
  logic [LcW-1:0]  lim, lc_inc;
  logic            char_ok;
  logic [4:0]      hex;
  logic [7:0]      c;
  logic            pay;
  logic [7:0]      ob;

  assign c       = item.in_byte;
  assign hex     = hex_digit(c);
  assign lim_ext = LimW'(line_limit);
  assign lc_inc  = line_count + 1'b1;
  assign char_ok = lc_inc < lim;
  assign lim     = lim_wide[LcW-1:0];

  always_comb begin
    if (line_limit == '0) begin
      lim_wide = LimW'(1);
    end else if (lim_ext > LineMaxV) begin
      lim_wide = LineMaxV;
    end else begin
      lim_wide = lim_ext;
    end
  end

  always_comb begin
    phase_next         = phase;
    line_count_next    = line_count;
    size_accum_next    = size_accum;
    bytes_left_next    = bytes_left;
    delivered_next     = delivered;
    number_closed_next = number_closed;
    saw_digit_next     = saw_digit;
    pay                = 1'b0;
    ob                 = '0;
    if (item.restart) begin
      phase_next         = PH_SIZE;
      line_count_next    = '0;
      size_accum_next    = '0;
      bytes_left_next    = '0;
      delivered_next     = '0;
      number_closed_next = 1'b0;
      saw_digit_next     = 1'b0;
    end else if (phase == PH_DONE || phase == PH_ERR) begin
      phase_next = phase;
    end else if (phase == PH_DATA) begin
      if (delivered == COUNT_MAX) begin
        phase_next = PH_ERR;
      end else begin
        delivered_next  = delivered + 1'b1;
        pay             = 1'b1;
        ob              = c;
        bytes_left_next = bytes_left - 1'b1;
        if (bytes_left == SIZE_BITS'(1)) begin
          phase_next = PH_TAIL;
        end
      end
    end else if (c == CH_CR) begin
      phase_next = phase;
    end else begin
      unique case (phase)
        PH_TAIL: begin
          phase_next = (c == CH_LF) ? PH_SIZE : PH_ERR;
        end
        PH_FOOT: begin
          if (c == CH_LF) begin
            if (line_count == '0) begin
              phase_next = PH_DONE;
            end
            line_count_next = '0;
          end else begin
            line_count_next = lc_inc;
            if (!char_ok) begin
              phase_next = PH_ERR;
            end
          end
        end
        PH_SIZE: begin
          if (c == CH_LF) begin
            line_count_next    = '0;
            size_accum_next    = '0;
            number_closed_next = 1'b0;
            saw_digit_next     = 1'b0;
            if (size_accum == '0) begin
              phase_next = (delivered == '0) ? PH_ERR : PH_FOOT;
            end else begin
              bytes_left_next = size_accum;
              phase_next      = PH_DATA;
            end
          end else begin
            line_count_next = lc_inc;
            if (!char_ok) begin
              phase_next = PH_ERR;
            end else if (number_closed) begin
              phase_next = phase;
            end else if (!hex[4]) begin
              if (c == CH_MINUS && !saw_digit) begin
                phase_next = PH_ERR;
              end else begin
                number_closed_next = 1'b1;
              end
            end else if (|size_accum[SIZE_BITS-1 -: 4]) begin
              // Shifting in another digit would carry out of the size field.
              phase_next = PH_ERR;
            end else begin
              size_accum_next = {size_accum[SIZE_BITS-5:0], hex[3:0]};
              saw_digit_next  = 1'b1;
            end
          end
        end
        default: begin
          phase_next = PH_ERR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_SIZE;
      line_count    <= '0;
      size_accum    <= '0;
      bytes_left    <= '0;
      delivered     <= '0;
      number_closed <= 1'b0;
      saw_digit     <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      line_count    <= line_count_next;
      size_accum    <= size_accum_next;
      bytes_left    <= bytes_left_next;
      delivered     <= delivered_next;
      number_closed <= number_closed_next;
      saw_digit     <= saw_digit_next;
    end
  end

  always_comb begin
    result.out_byte      = ob;
    result.payload_valid = pay;
    result.total_bytes   = delivered_next;
    if (phase_next == PH_DONE) begin
      result.body_status = ST_DONE;
    end else if (phase_next == PH_ERR) begin
      result.body_status = ST_ERR;
    end else begin
      result.body_status = ST_RUN;
    end
  end

  a_restart_clears: assert property (@(posedge clk) disable iff (rst)
    accept && item.restart |=> phase == PH_SIZE && delivered == '0 && size_accum == '0)
    else $error("restart did not clear the decode state");

  a_payload_in_data: assert property (@(posedge clk) disable iff (rst)
    result.payload_valid |-> phase == PH_DATA && bytes_left != '0)
    else $error("payload word outside a chunk");

  a_final_holds: assert property (@(posedge clk) disable iff (rst)
    accept && !item.restart && (phase == PH_DONE || phase == PH_ERR) |=> $stable(phase))
    else $error("done or error state left without restart");

  a_count_grows: assert property (@(posedge clk) disable iff (rst)
    accept && !item.restart |=> delivered >= $past(delivered))
    else $error("delivered count went down");

endmodule

[rtl/chd_outreg.sv]
// Output register: holds one result word until the downstream side takes it.
// Depends on chd_pkg.
module chd_outreg import chd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  out_item_t load_data,
  output logic      busy,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  // A new word may enter whenever the held one is leaving or there is none.
  assign busy = out_valid & out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule
